// File: design/gnd_pkg.sv
package gnd_pkg;

	// Default values for the parameters of the top level.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ANGLE_BITS_DEF = 8;
	localparam int MAX_REROLL_DEF = 15;

	// Width of one register word.
	localparam int REROLL_W = 4;

	// Width of one gradient component in Q.16; a unit vector needs a sign and 17 bits.
	localparam int GRAD_W = 18;

	// Hash constants.
	localparam logic [31:0] HASH_MUL_A = 32'd747796405;
	localparam logic [31:0] HASH_ADD_A = 32'd2891336453;
	localparam logic [31:0] HASH_MUL_B = 32'd277803737;

	// Output scaling: 1/1.414 in Q.16 and the half-scale offset.
	localparam int SCALE_K  = 46348;
	localparam int HALF_OUT = 32768;

	// Rotation gain and arctangent steps in turns scaled by 2^32.
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint ATAN_TURNS [16] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004757,
		64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
		64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
		64'sd166886, 64'sd83443, 64'sd41721, 64'sd20861
	};

	// First half of the hash: multiply-add, then the data-dependent shift.
	function automatic logic [31:0] hash_a(input logic [31:0] n);
		logic [31:0] st;
		begin
			st = n * HASH_MUL_A + HASH_ADD_A;
			return (st >> ({1'b0, st[31:28]} + 5'd4)) ^ st;
		end
	endfunction

	// Second half of the hash: multiply, then fold the top bits down.
	function automatic logic [31:0] hash_b(input logic [31:0] v);
		logic [31:0] w;
		begin
			w = v * HASH_MUL_B;
			return (w >> 22) ^ w;
		end
	endfunction

	// One component of the unit gradient for angle code k. Only evaluated
	// while the design elaborates, to fill the gradient table.
	function automatic logic signed [GRAD_W-1:0] grad_comp(
		input int unsigned k, input int unsigned ab, input bit want_y);
		logic [31:0] p;
		logic [31:0] pq;
		bit          flip;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		longint      r;
		begin
			p    = 32'(k << (32 - ab));
			pq   = p + 32'h4000_0000;
			flip = pq[31];
			if (flip) begin
				p = p - 32'h8000_0000;
			end
			x = CORDIC_GAIN;
			y = 0;
			z = longint'($signed(p));
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - ATAN_TURNS[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + ATAN_TURNS[i];
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			r = ((want_y ? y : x) + 64'sd8192) >>> 14;
			return GRAD_W'(r);
		end
	endfunction

endpackage

// File: design/gradient_noise_2d.sv
// Throughput: one word per cycle; a stalled output only holds the stages that are full.
// Reset (arst_n low, asynchronous): all stage valid bits clear and reroll_q returns
// to 0. Data registers are not reset.
module gradient_noise_2d #(
	parameter int FRAC_BITS  = gnd_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS = gnd_pkg::ANGLE_BITS_DEF,
	parameter int MAX_REROLL = gnd_pkg::MAX_REROLL_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gnd_pkg::REROLL_W-1:0]  cfg_wdata,
	input  logic                          pos_valid,
	output logic                          pos_ready,
	input  logic signed [31:0]            pos_x,
	input  logic signed [31:0]            pos_y,
	output logic                          noise_valid,
	input  logic                          noise_ready,
	output logic [15:0]                   noise
);

	// The pipeline, stage by stage:
	//   1        floor and fraction of both coordinates, upper corner.
	//   2..4     spiral label of each of the four corners (absolute values and ring,
	//            ring start square, side selection); in parallel the quintic fade.
	//   5..HL    the hash, two stages per application; applications beyond the
	//            configured reroll count pass the word through unchanged.
	//   HL+1     gradient table lookup.
	//   HL+2     corner dot products.
	//   HL+3     blend products with the fade weights.
	//   HL+4     sum of the blend terms.
	//   HL+5     scaling, offset and saturation into the output register.
	localparam int F   = FRAC_BITS;
	localparam int ONE = 1 << F;
	localparam int NA  = 1 << ANGLE_BITS;
	localparam int GW  = gnd_pkg::GRAD_W;
	localparam int HL  = 6 + 2 * MAX_REROLL;
	localparam int NS  = HL + 5;

	localparam int FA  = F + 5;       // fade a and b
	localparam int TAW = 2 * F + 6;   // t*a
	localparam int TTW = 2 * F;       // t*t and c*t
	localparam int DBW = 2 * F + 5;   // d*b
	localparam int UUW = 2 * F + 2;   // ux*uy
	localparam int VW  = F + 2;       // corner offset vector component
	localparam int PDW = VW + GW + 1; // dot product before scaling
	localparam int DW  = GW + 3;      // dot product in Q.16
	localparam int SW  = DW + F + 6;  // blend sum
	localparam int RW  = SW + 17;     // scaled sum

	// Values carried alongside the hash chain: fractions, fade weights and their product.
	typedef struct packed {
		logic [1:0][F-1:0] t;
		logic [1:0][F:0]   u;
		logic [F:0]        w;
	} side_t;

	// Stage control. A stage may load when it is empty or when the stage after it loads,
	// so bubbles close up behind a stalled output word.
	logic [NS:1] vld_q;
	logic [NS:1] en;

	always_comb begin
		en[NS] = ~vld_q[NS] | noise_ready;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = ~vld_q[i] | en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pos_valid;
			end
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign pos_ready   = en[1];
	assign noise_valid = vld_q[NS];

	// The one configuration register.
	logic [gnd_pkg::REROLL_W-1:0] reroll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reroll_q <= '0;
		end else if (cfg_we) begin
			reroll_q <= cfg_wdata;
		end
	end

	// Stage 1: lattice cell and fraction. A whole coordinate keeps the upper corner
	// on the lower one.
	logic [31:0]  x0_s1, x1_s1, y0_s1, y1_s1;
	logic [1:0][F-1:0] t_s1;
	logic [31:0]  x0_in, y0_in;

	assign x0_in = 32'(pos_x >>> F);
	assign y0_in = 32'(pos_y >>> F);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x0_s1   <= x0_in;
			y0_s1   <= y0_in;
			x1_s1   <= (pos_x[F-1:0] != '0) ? x0_in + 32'd1 : x0_in;
			y1_s1   <= (pos_y[F-1:0] != '0) ? y0_in + 32'd1 : y0_in;
			t_s1[0] <= pos_x[F-1:0];
			t_s1[1] <= pos_y[F-1:0];
		end
	end

	// Stage 2: corner coordinates, their magnitudes and the ring number n. The ring
	// is the larger magnitude under a signed compare, as in the wrapping index maths.
	// Corner c: bit 0 selects the upper x, bit 1 the upper y.
	logic [31:0] cx_s2 [4];
	logic [31:0] cy_s2 [4];
	logic [31:0] n_s2 [4];
	logic [3:0]  zero_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int c = 0; c < 4; c++) begin
				logic [31:0] x, y, ax, ay;
				x  = c[0] ? x1_s1 : x0_s1;
				y  = c[1] ? y1_s1 : y0_s1;
				ax = x[31] ? 32'd0 - x : x;
				ay = y[31] ? 32'd0 - y : y;
				cx_s2[c]   <= x;
				cy_s2[c]   <= y;
				n_s2[c]    <= ($signed(ax) > $signed(ay)) ? ax : ay;
				zero_s2[c] <= (x == '0) && (y == '0);
			end
		end
	end

	// Stage 3: ring width and the square that precedes the ring.
	logic [31:0] cx_s3 [4];
	logic [31:0] cy_s3 [4];
	logic [31:0] n_s3 [4];
	logic [31:0] width_s3 [4];
	logic [31:0] start_s3 [4];
	logic [3:0]  zero_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < 4; c++) begin
				logic [31:0] side;
				side = {n_s2[c][30:0], 1'b0} - 32'd1;
				cx_s3[c]    <= cx_s2[c];
				cy_s3[c]    <= cy_s2[c];
				n_s3[c]     <= n_s2[c];
				width_s3[c] <= {n_s2[c][30:0], 1'b1};
				start_s3[c] <= side * side;
				zero_s3[c]  <= zero_s2[c];
			end
		end
	end

	// Stage 4: spiral label. The sides are tried top, bottom, right, left and the
	// first that matches wins.
	logic [31:0] label_s4 [4];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int c = 0; c < 4; c++) begin
				logic [31:0] x, y, n, wd, st;
				x  = cx_s3[c];
				y  = cy_s3[c];
				n  = n_s3[c];
				wd = width_s3[c];
				st = start_s3[c];
				priority if (zero_s3[c]) begin
					label_s4[c] <= '0;
				end else if (n == y) begin
					label_s4[c] <= st + x + n;
				end else if (n == 32'd0 - y) begin
					label_s4[c] <= st + wd + x + n;
				end else if (n == x) begin
					label_s4[c] <= st + {wd[30:0], 1'b0} + y - 32'd1 + n;
				end else if (n == 32'd0 - x) begin
					label_s4[c] <= st + wd * 32'd3 - 32'd2 + y - 32'd1 + n;
				end else begin
					label_s4[c] <= '0;
				end
			end
		end
	end

	// Fade, stages 2 to 5, for x (index 0) and y (index 1):
	// a = 6t - 15, b = t*a + 10, c = t*t, d = c*t, u = d*b, then w = ux*uy.
	logic signed [TAW-1:0] ta_s2 [2];
	logic [TTW-1:0]        tt_s2 [2];
	logic [1:0][F-1:0]     t_s2;
	logic [FA-1:0]         b_s3 [2];
	logic [F-1:0]          d_s3 [2];
	logic [1:0][F-1:0]     t_s3;
	logic [1:0][F:0]       u_s4;
	logic [1:0][F-1:0]     t_s4;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 2; k++) begin
				logic signed [FA-1:0] a;
				a = FA'(6 * int'(t_s1[k]) - 15 * ONE);
				ta_s2[k] <= TAW'($signed({1'b0, t_s1[k]}) * a);
				tt_s2[k] <= TTW'(t_s1[k]) * TTW'(t_s1[k]);
			end
			t_s2 <= t_s1;
		end
		if (en[3]) begin
			for (int k = 0; k < 2; k++) begin
				logic [TTW-1:0] ct;
				ct = TTW'(tt_s2[k][TTW-1:F]) * TTW'(t_s2[k]);
				b_s3[k] <= FA'(ta_s2[k] >>> F) + FA'(10 * ONE);
				d_s3[k] <= ct[TTW-1:F];
			end
			t_s3 <= t_s2;
		end
		if (en[4]) begin
			for (int k = 0; k < 2; k++) begin
				logic [DBW-1:0] db;
				db = DBW'(d_s3[k]) * DBW'(b_s3[k]);
				u_s4[k] <= db[2*F:F];
			end
			t_s4 <= t_s3;
		end
	end

	// Side values from stage 5 up to the blend stage.
	side_t side_sd [5:HL+2];

	always_ff @(posedge clk) begin
		if (en[5]) begin
			logic [UUW-1:0] uu;
			uu = UUW'(u_s4[0]) * UUW'(u_s4[1]);
			side_sd[5].t <= t_s4;
			side_sd[5].u <= u_s4;
			side_sd[5].w <= uu[2*F:F];
		end
	end

	for (genvar s = 6; s <= HL + 2; s++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[s]) begin
				side_sd[s] <= side_sd[s-1];
			end
		end
	end

	// Hash chain. Application j occupies stages 5+2j and 6+2j; the first always
	// applies, the others only while j does not exceed the reroll count.
	logic [31:0] hn_sha [MAX_REROLL+1][4];
	logic [31:0] hv_sha [MAX_REROLL+1][4];
	logic [31:0] hb_shb [MAX_REROLL+1][4];

	for (genvar j = 0; j <= MAX_REROLL; j++) begin : g_hash
		localparam int SA = 5 + 2 * j;
		logic [31:0] src [4];
		logic        apply;

		if (j == 0) begin : g_first
			assign src = label_s4;
		end else begin : g_next
			assign src = hb_shb[j-1];
		end

		assign apply = 32'(reroll_q) >= 32'(j);

		always_ff @(posedge clk) begin
			if (en[SA]) begin
				for (int c = 0; c < 4; c++) begin
					hn_sha[j][c] <= src[c];
					hv_sha[j][c] <= gnd_pkg::hash_a(src[c]);
				end
			end
			if (en[SA+1]) begin
				for (int c = 0; c < 4; c++) begin
					hb_shb[j][c] <= apply ? gnd_pkg::hash_b(hv_sha[j][c]) : hn_sha[j][c];
				end
			end
		end
	end

	// Gradient table, filled when the design elaborates.
	logic signed [GW-1:0] lut_gx [NA];
	logic signed [GW-1:0] lut_gy [NA];

	for (genvar g = 0; g < NA; g++) begin : g_lut
		assign lut_gx[g] = gnd_pkg::grad_comp(g, ANGLE_BITS, 1'b0);
		assign lut_gy[g] = gnd_pkg::grad_comp(g, ANGLE_BITS, 1'b1);
	end

	// Stage HL+1: gradient lookup from the top bits of the final hash.
	logic signed [GW-1:0] gx_sg1 [4];
	logic signed [GW-1:0] gy_sg1 [4];

	always_ff @(posedge clk) begin
		if (en[HL+1]) begin
			for (int c = 0; c < 4; c++) begin
				gx_sg1[c] <= lut_gx[hb_shb[MAX_REROLL][c][31 -: ANGLE_BITS]];
				gy_sg1[c] <= lut_gy[hb_shb[MAX_REROLL][c][31 -: ANGLE_BITS]];
			end
		end
	end

	// Stage HL+2: dot product of the corner offset with its gradient.
	logic signed [DW-1:0] dot_sg2 [4];

	always_ff @(posedge clk) begin
		if (en[HL+2]) begin
			for (int c = 0; c < 4; c++) begin
				logic signed [VW-1:0]  vx, vy;
				logic signed [PDW-1:0] pd;
				vx = $signed({2'b00, side_sd[HL+1].t[0]}) - (c[0] ? VW'(ONE) : VW'(0));
				vy = $signed({2'b00, side_sd[HL+1].t[1]}) - (c[1] ? VW'(ONE) : VW'(0));
				pd = PDW'(vx * gx_sg1[c]) + PDW'(vy * gy_sg1[c]);
				dot_sg2[c] <= DW'(pd >>> F);
			end
		end
	end

	// Stage HL+3: bilinear blend terms weighted by the fade values.
	logic signed [SW-1:0] term_sg3 [4];

	always_ff @(posedge clk) begin
		if (en[HL+3]) begin
			logic signed [DW:0]   dx, dy;
			logic signed [DW+1:0] dxy;
			logic signed [F+1:0]  ux, uy, w;
			dx  = (DW+1)'(dot_sg2[1]) - (DW+1)'(dot_sg2[0]);
			dy  = (DW+1)'(dot_sg2[2]) - (DW+1)'(dot_sg2[0]);
			dxy = (DW+2)'(dot_sg2[0]) - (DW+2)'(dot_sg2[1])
			    - (DW+2)'(dot_sg2[2]) + (DW+2)'(dot_sg2[3]);
			ux  = $signed({1'b0, side_sd[HL+2].u[0]});
			uy  = $signed({1'b0, side_sd[HL+2].u[1]});
			w   = $signed({1'b0, side_sd[HL+2].w});
			term_sg3[0] <= SW'(dot_sg2[0]) <<< F;
			term_sg3[1] <= SW'(ux * dx);
			term_sg3[2] <= SW'(uy * dy);
			term_sg3[3] <= SW'(w * dxy);
		end
	end

	// Stage HL+4: sum of the blend terms.
	logic signed [SW-1:0] sum_sg4;

	always_ff @(posedge clk) begin
		if (en[HL+4]) begin
			sum_sg4 <= term_sg3[0] + term_sg3[1] + term_sg3[2] + term_sg3[3];
		end
	end

	// Stage HL+5: scale by 1/1.414 with rounding, add one half and clamp to 16 bits.
	// This register is also the output register.
	logic [15:0] noise_sg5;

	always_ff @(posedge clk) begin
		if (en[HL+5]) begin
			logic signed [RW-1:0] sc;
			logic signed [RW-1:0] r;
			sc = RW'(sum_sg4 * $signed(RW'(gnd_pkg::SCALE_K))) + (RW'(1) <<< (F + 15));
			r  = (sc >>> (F + 16)) + RW'(gnd_pkg::HALF_OUT);
			priority if (r < 0) begin
				noise_sg5 <= '0;
			end else if (r > RW'(65535)) begin
				noise_sg5 <= 16'hFFFF;
			end else begin
				noise_sg5 <= r[15:0];
			end
		end
	end

	assign noise = noise_sg5;

endmodule

// File: design/gnd_checker.sv
module gnd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pos_valid,
	input logic        pos_ready,
	input logic        noise_valid,
	input logic        noise_ready,
	input logic [15:0] noise
);

	// Words accepted at the input whose noise word has not yet been taken.
	logic [7:0] open_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 8'(pos_valid && pos_ready) - 8'(noise_valid && noise_ready);
		end
	end

	// A waiting noise word is held unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && !noise_ready |=> noise_valid && $stable(noise))
		else $error("noise word changed or dropped while stalled");

	// Every noise word answers an earlier position word.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid |-> open_q != 8'd0)
		else $error("noise word with no position word outstanding");

	// The input only stalls when the output is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pos_ready |-> noise_valid && !noise_ready)
		else $error("input stalled without back-pressure at the output");

endmodule

bind gradient_noise_2d gnd_checker u_gnd_checker (.*);

// File: test/gnd_checker.sv
`default_nettype none

module gnd_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	input  wire logic        pos_valid,
	input  wire logic        pos_ready,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic        noise_valid,
	input  wire logic        noise_ready,
	input  wire logic [15:0] noise,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = gnd_pkg::FRAC_BITS_DEF;
	localparam int AB = gnd_pkg::ANGLE_BITS_DEF;
	localparam longint ONE = 64'sd1 <<< FB;

	localparam longint ARC [16] = '{
		64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004757,
		64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
		64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
		64'sd166886, 64'sd83443, 64'sd41721, 64'sd20861
	};

	logic [3:0]  reroll;
	logic [15:0] noise_due [$];
	int          words_seen;

	function automatic logic [31:0] mix(input logic [31:0] n);
		logic [31:0] st;
		logic [31:0] w;
		begin
			st = n * 32'd747796405 + 32'd2891336453;
			w  = ((st >> (st[31:28] + 4)) ^ st) * 32'd277803737;
			return (w >> 22) ^ w;
		end
	endfunction

	function automatic logic [31:0] ring_label(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] n;
		logic [31:0] wd;
		logic [31:0] st;
		begin
			if (x == 0 && y == 0)
				return 32'd0;
			ax = x[31] ? -x : x;
			ay = y[31] ? -y : y;
			n  = ($signed(ax) > $signed(ay)) ? ax : ay;
			wd = 2 * n + 1;
			st = (wd - 2) * (wd - 2);
			if (n == y)
				return st + x + n;
			if (n == -y)
				return st + wd + x + n;
			if (n == x)
				return st + wd * 2 + y - 1 + n;
			if (n == -x)
				return st + wd * 3 - 2 + y - 1 + n;
			return 32'd0;
		end
	endfunction

	// Unit gradient by rotating the gain vector to the angle held in the hash's top bits.
	function automatic void unit_grad(input logic [31:0] h, output longint gx,
		output longint gy);
		logic [31:0] p;
		logic [31:0] pq;
		longint      x;
		longint      y;
		longint      z;
		longint      nx;
		bit          flip;
		begin
			p    = (h >> (32 - AB)) << (32 - AB);
			pq   = p + 32'h4000_0000;
			flip = pq[31];
			if (flip)
				p = p - 32'h8000_0000;
			x = 64'sd652032874;
			y = 0;
			z = longint'($signed(p));
			for (int i = 0; i < 16; i++) begin
				if (z >= 0) begin
					nx = x - (y >>> i);
					y  = y + (x >>> i);
					z  = z - ARC[i];
				end else begin
					nx = x + (y >>> i);
					y  = y - (x >>> i);
					z  = z + ARC[i];
				end
				x = nx;
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			gx = (x + 8192) >>> 14;
			gy = (y + 8192) >>> 14;
		end
	endfunction

	function automatic longint corner(input logic [31:0] lbl, input int reps,
		input longint vx, input longint vy);
		logic [31:0] h;
		longint      gx;
		longint      gy;
		begin
			h = mix(lbl);
			for (int i = 0; i < reps; i++)
				h = mix(h);
			unit_grad(h, gx, gy);
			return (vx * gx + vy * gy) >>> FB;
		end
	endfunction

	function automatic longint quintic(input longint t);
		longint a;
		longint b;
		longint c;
		longint d;
		begin
			a = 6 * t - 15 * ONE;
			b = ((t * a) >>> FB) + 10 * ONE;
			c = (t * t) >>> FB;
			d = (c * t) >>> FB;
			return (d * b) >>> FB;
		end
	endfunction

	function automatic logic [15:0] noise_at(input logic [31:0] px, input logic [31:0] py,
		input int reps);
		longint      tx;
		longint      ty;
		logic [31:0] x0;
		logic [31:0] y0;
		logic [31:0] x1;
		logic [31:0] y1;
		longint      d00;
		longint      d10;
		longint      d01;
		longint      d11;
		longint      ux;
		longint      uy;
		longint      w;
		longint      s;
		longint      r;
		begin
			tx = longint'(px & (ONE - 1));
			ty = longint'(py & (ONE - 1));
			x0 = 32'($signed(px) >>> FB);
			y0 = 32'($signed(py) >>> FB);
			// A whole coordinate keeps both corners in the same cell column or row.
			x1 = (tx != 0) ? x0 + 1 : x0;
			y1 = (ty != 0) ? y0 + 1 : y0;
			d00 = corner(ring_label(x0, y0), reps, tx, ty);
			d10 = corner(ring_label(x1, y0), reps, tx - ONE, ty);
			d01 = corner(ring_label(x0, y1), reps, tx, ty - ONE);
			d11 = corner(ring_label(x1, y1), reps, tx - ONE, ty - ONE);
			ux = quintic(tx);
			uy = quintic(ty);
			w  = (ux * uy) >>> FB;
			s  = d00 * ONE + ux * (d10 - d00) + uy * (d01 - d00) + w * (d00 - d10 - d01 + d11);
			r  = ((s * 46348 + (64'sd1 <<< (FB + 15))) >>> (FB + 16)) + 32768;
			if (r < 0)
				r = 0;
			if (r > 65535)
				r = 65535;
			return 16'(r);
		end
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		reroll     = '0;
		words_seen = 0;
	end

	assign pending = noise_due.size();

	// Sampled mid-cycle, so the values seen here are those the next rising edge will take.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				reroll <= cfg_wdata;
			if (pos_valid && pos_ready)
				noise_due.push_back(noise_at(pos_x, pos_y, int'(reroll)));
			if (noise_valid && noise_ready) begin
				words_seen++;
				if (noise_due.size() == 0)
					report($sformatf("noise word %0d (%0d) with none expected",
						words_seen, noise));
				else if (noise !== noise_due[0])
					report($sformatf("noise word %0d: got %0d, want %0d",
						words_seen, noise, noise_due.pop_front()));
				else
					void'(noise_due.pop_front());
			end
		end
	end
endmodule

`default_nettype wire

// File: test/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Latency of the block with its default reroll bound, plus a margin.
	localparam int SETTLE = 60;
	// Longest stretch of cycles with no word moving on either channel.
	localparam int STALL_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        pos_valid;
	logic        pos_ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic        noise_valid;
	logic        noise_ready;
	logic [15:0] noise;
	int          fail_count;
	int          pending;

	// When set, neither side inserts idle cycles any more.
	bit          calm;
	bit          pos_taken;
	int          ready_hold;
	int          quiet_cycles;

	gradient_noise_2d dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pos_valid  (pos_valid),
		.pos_ready  (pos_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.noise_valid(noise_valid),
		.noise_ready(noise_ready),
		.noise      (noise)
	);

	gnd_monitor u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pos_valid  (pos_valid),
		.pos_ready  (pos_ready),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.noise_valid(noise_valid),
		.noise_ready(noise_ready),
		.noise      (noise),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Handshakes are sampled mid-cycle; inputs only move at rising edges, so the flag
	// tells whether a word passes at the following edge.
	always @(negedge clk) begin
		pos_taken <= pos_valid && pos_ready;
		if ((pos_valid && pos_ready) || (noise_valid && noise_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// The receiver holds off in bursts at random until the calm part of the run.
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			noise_ready <= 1'b0;
			ready_hold  <= ready_hold - 1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			noise_ready <= 1'b0;
			ready_hold  <= $urandom_range(0, 8);
		end else begin
			noise_ready <= 1'b1;
		end
	end

	// Presents one position word and returns at the edge that takes it.
	task automatic send_pos(input logic [31:0] x, input logic [31:0] y);
		int gap;
		begin
			if (!calm && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 9);
				pos_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pos_valid <= 1'b1;
			pos_x     <= x;
			pos_y     <= y;
			@(posedge clk);
			while (!pos_taken)
				@(posedge clk);
		end
	endtask

	// Lets every expected noise word arrive, then gives the pipeline time to empty.
	task automatic drain();
		pos_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reroll(input logic [3:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Random positions: mostly near the origin, where the spiral sides and the cell
	// boundaries are crossed often, with whole coordinates and full-range values mixed in.
	function automatic logic [31:0] pick_coord();
		logic [31:0] v;
		begin
			case ($urandom_range(0, 5))
				0, 1: v = {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
				2: v = {16'($urandom_range(0, 15) - 8), 16'h0000};
				3: v = {16'($urandom_range(0, 7) - 4), 16'($urandom)};
				default: v = $urandom;
			endcase
			return v;
		end
	endfunction

	task automatic random_run(input int count);
		for (int i = 0; i < count; i++)
			send_pos(pick_coord(), pick_coord());
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		pos_valid    = 1'b0;
		pos_x        = '0;
		pos_y        = '0;
		noise_ready  = 1'b0;
		calm         = 1'b0;
		pos_taken    = 1'b0;
		ready_hold   = 0;
		quiet_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words with the reset value of the reroll count: the origin, whole
		// coordinates, both signs, the extreme coordinates and each side of the spiral.
		send_pos(32'h0000_0000, 32'h0000_0000);
		send_pos(32'h0000_8000, 32'h0000_8000);
		send_pos(32'h0001_0000, 32'h0000_0000);
		send_pos(32'h0000_0000, 32'hFFFF_0000);
		send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pos(32'h0000_0001, 32'h0000_0001);
		send_pos(32'h0000_FFFF, 32'h0000_FFFF);
		send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pos(32'h8000_0000, 32'h8000_0000);
		send_pos(32'h8000_0000, 32'h7FFF_FFFF);
		send_pos(32'h7FFF_0000, 32'h8000_0000);
		send_pos(32'h0002_4000, 32'h0001_C000);
		send_pos(32'h0001_4000, 32'hFFFD_C000);
		send_pos(32'h0003_2000, 32'h0001_2000);
		send_pos(32'hFFFC_E000, 32'h0001_6000);
		send_pos(32'hFFFE_8000, 32'hFFFE_8000);
		send_pos(32'h5555_5555, 32'hAAAA_AAAA);
		send_pos(32'hAAAA_AAAA, 32'h5555_5555);
		drain();

		set_reroll(4'd15);
		send_pos(32'h0000_0000, 32'h0000_0000);
		send_pos(32'h0001_8000, 32'hFFFF_8000);
		send_pos(32'h7FFF_FFFF, 32'h8000_0000);
		random_run(300);
		drain();

		set_reroll(4'd0);
		random_run(300);
		drain();

		set_reroll(4'($urandom_range(1, 14)));
		random_run(300);
		drain();

		set_reroll(4'd1);
		random_run(300);
		drain();

		set_reroll(4'($urandom_range(2, 13)));
		random_run(300);
		drain();

		// Last stretch at full rate on both channels.
		set_reroll(4'd15);
		calm = 1'b1;
		random_run(280);
		drain();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

`default_nettype wire
